FILE: hdl/dhcp_roc_pkg.sv
// DHCP reply option checker: shared word types, watched option codes, verdict codes.
// No dependencies; used by every module in hdl/.
package dhcp_roc_pkg;

    localparam int NUM_WATCH    = 10;
    localparam int NUM_REQUIRED = 8;
    localparam int BIT_TYPE     = 8;
    localparam int BIT_SERVER   = 9;

    localparam logic [7:0] WATCH_CODES [NUM_WATCH] =
        '{8'd1, 8'd3, 8'd6, 8'd15, 8'd51, 8'd82, 8'd26, 8'd28, 8'd53, 8'd54};

    localparam logic [7:0] TYPE_OFFER = 8'd2;
    localparam logic [7:0] TYPE_ACK   = 8'd5;

    typedef enum logic [2:0] {
        VERDICT_OFFER    = 3'd0,
        VERDICT_ACK      = 3'd1,
        VERDICT_OTHER    = 3'd2,
        VERDICT_NO_TYPE  = 3'd3,
        VERDICT_NO_SERVER = 3'd4,
        VERDICT_MISSING  = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic [7:0] reply_type;
        logic [7:0] missing_code;
    } result_t;

    // what the walk leaves at the last byte of a reply
    typedef struct packed {
        logic [NUM_WATCH-1:0] seen_mask;
        logic                 type_valid;
        logic [7:0]           type_value;
    } summary_t;

endpackage

FILE: hdl/dhcp_reply_option_checker_core.sv
// Top level of the DHCP reply option checker: walker, summary queue, verdict stage.
// Depends on dhcp_roc_pkg, dhcp_roc_front, dhcp_roc_queue, dhcp_roc_back.
//
// Input channel: one option-area byte per word (push/full), starting after the
// magic cookie; last_byte marks the end of a reply. Result channel (empty/pop):
// one word per reply with verdict, message type and first missing required code.
// Config: cfg_wr_en/cfg_wr_data set check_required; write only while idle.
// Throughput: one byte per cycle while full is low. The walker updates its phase,
// skip count and option mask for each byte that it takes.
// Path: the summary of a reply is written into the queue at the edge that accepts
// its last byte; the verdict stage then registers its result from the queue.
// Stall: while pop stays low the result is held; up to QUEUE_DEPTH further
// summaries queue behind it, then full rises and bytes wait.
// Reset: asynchronous, clears the walk state, the queue, the result valid flag
// and check_required; the result data register itself is not reset.
module dhcp_reply_option_checker_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  dhcp_roc_pkg::item_t   item,
    output logic                  empty,
    input  logic                  pop,
    output dhcp_roc_pkg::result_t result,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data
);

    logic                   check_reg;
    logic                   take;
    logic                   sum_write;
    dhcp_roc_pkg::summary_t sum_word;
    dhcp_roc_pkg::summary_t q_word;
    logic                   q_full, q_empty, q_pop;

    assign full = q_full;
    assign take = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            check_reg <= cfg_wr_data;
        end
    end

    dhcp_roc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .sum_write (sum_write),
        .sum_word  (sum_word)
    );

    dhcp_roc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sum_write),
        .wr_word (sum_word),
        .rd_en   (q_pop),
        .rd_word (q_word),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    dhcp_roc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .check_required (check_reg),
        .q_empty        (q_empty),
        .q_word         (q_word),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .result         (result)
    );

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sum_write |-> !q_full)
        else $error("summary written into full queue");

    a_missing_code_set: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.verdict == dhcp_roc_pkg::VERDICT_MISSING)
            |-> (result.missing_code != 8'd0 && check_reg))
        else $error("missing verdict without code or check enabled");

    a_missing_code_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.verdict != dhcp_roc_pkg::VERDICT_MISSING)
            |-> result.missing_code == 8'd0)
        else $error("missing code set on other verdict");

    a_no_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.verdict == dhcp_roc_pkg::VERDICT_NO_TYPE)
            |-> result.reply_type == 8'd0)
        else $error("message type nonzero without type");

endmodule

FILE: hdl/dhcp_roc_front.sv
// Option walker: code/length/data phases, watched-option mask, type capture.
// Emits one summary word per reply. Depends on dhcp_roc_pkg.
module dhcp_roc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  dhcp_roc_pkg::item_t   item,
    output logic                  sum_write,
    output dhcp_roc_pkg::summary_t sum_word
);

    typedef enum logic [1:0] {
        PH_CODE = 2'd0,
        PH_LEN  = 2'd1,
        PH_SKIP = 2'd2
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [7:0]                         skip_reg, skip_next;
    logic [dhcp_roc_pkg::NUM_WATCH-1:0] mask_reg, mask_next;
    logic [7:0]                         type_reg, type_next;
    logic                               tvalid_reg, tvalid_next;
    logic                               capture_reg, capture_next;
    logic [dhcp_roc_pkg::NUM_WATCH-1:0] hit;
    logic [7:0]                         skip_dec;

    always_comb
    begin
        for (int i = 0; i < dhcp_roc_pkg::NUM_WATCH; i++)
        begin
            hit[i] = (item.option_byte == dhcp_roc_pkg::WATCH_CODES[i]);
        end
    end

    assign skip_dec = skip_reg - 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        mask_next    = mask_reg;
        type_next    = type_reg;
        tvalid_next  = tvalid_reg;
        capture_next = capture_reg;

        if (capture_reg && phase_reg != PH_LEN)
        begin
            type_next    = item.option_byte;
            tvalid_next  = 1'b1;
            capture_next = 1'b0;
        end

        case (phase_reg)
            PH_LEN:
            begin
                if (item.option_byte == 8'd0)
                begin
                    phase_next = PH_CODE;
                end
                else
                begin
                    skip_next  = item.option_byte;
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 8'd0)
                begin
                    phase_next = PH_CODE;
                end
            end
            default:
            begin
                if (hit[dhcp_roc_pkg::BIT_TYPE] && !mask_reg[dhcp_roc_pkg::BIT_TYPE])
                begin
                    capture_next = 1'b1;
                end
                mask_next  = mask_reg | hit;
                phase_next = PH_LEN;
            end
        endcase
    end

    assign sum_write           = take && item.last_byte;
    assign sum_word.seen_mask  = mask_next;
    assign sum_word.type_valid = tvalid_next;
    assign sum_word.type_value = type_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CODE;
            skip_reg    <= 8'd0;
            mask_reg    <= '0;
            type_reg    <= 8'd0;
            tvalid_reg  <= 1'b0;
            capture_reg <= 1'b0;
        end
        else if (take)
        begin
            if (item.last_byte)
            begin
                phase_reg   <= PH_CODE;
                skip_reg    <= 8'd0;
                mask_reg    <= '0;
                type_reg    <= 8'd0;
                tvalid_reg  <= 1'b0;
                capture_reg <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                skip_reg    <= skip_next;
                mask_reg    <= mask_next;
                type_reg    <= type_next;
                tvalid_reg  <= tvalid_next;
                capture_reg <= capture_next;
            end
        end
    end

endmodule

FILE: hdl/dhcp_roc_queue.sv
// Short register queue of summary words between walker and verdict stage.
// Depends on dhcp_roc_pkg for the word type.
module dhcp_roc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  dhcp_roc_pkg::summary_t wr_word,
    input  logic                   rd_en,
    output dhcp_roc_pkg::summary_t rd_word,
    output logic                   q_full,
    output logic                   q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dhcp_roc_pkg::summary_t mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_wr, do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_word = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/dhcp_roc_back.sv
// Verdict stage: turns a summary word into a result word held in an output register.
// Depends on dhcp_roc_pkg.
module dhcp_roc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   check_required,
    input  logic                   q_empty,
    input  dhcp_roc_pkg::summary_t q_word,
    output logic                   q_pop,
    input  logic                   pop,
    output logic                   empty,
    output dhcp_roc_pkg::result_t  result
);

    logic                  valid_reg;
    dhcp_roc_pkg::result_t result_reg, result_next;
    logic                  missing_any;
    logic [7:0]            missing_code;

    // first missing required option, checked order
    always_comb
    begin
        missing_any  = 1'b0;
        missing_code = 8'd0;
        for (int i = dhcp_roc_pkg::NUM_REQUIRED - 1; i >= 0; i--)
        begin
            if (!q_word.seen_mask[i])
            begin
                missing_any  = 1'b1;
                missing_code = dhcp_roc_pkg::WATCH_CODES[i];
            end
        end
    end

    always_comb
    begin
        result_next.reply_type   = q_word.type_valid ? q_word.type_value : 8'd0;
        result_next.missing_code = 8'd0;
        if (!q_word.type_valid)
        begin
            result_next.verdict = dhcp_roc_pkg::VERDICT_NO_TYPE;
        end
        else if (!q_word.seen_mask[dhcp_roc_pkg::BIT_SERVER])
        begin
            result_next.verdict = dhcp_roc_pkg::VERDICT_NO_SERVER;
        end
        else if (check_required && missing_any)
        begin
            result_next.verdict      = dhcp_roc_pkg::VERDICT_MISSING;
            result_next.missing_code = missing_code;
        end
        else if (q_word.type_value == dhcp_roc_pkg::TYPE_OFFER)
        begin
            result_next.verdict = dhcp_roc_pkg::VERDICT_OFFER;
        end
        else if (q_word.type_value == dhcp_roc_pkg::TYPE_ACK)
        begin
            result_next.verdict = dhcp_roc_pkg::VERDICT_ACK;
        end
        else
        begin
            result_next.verdict = dhcp_roc_pkg::VERDICT_OTHER;
        end
    end

    assign q_pop  = !q_empty && (!valid_reg || pop);
    assign empty  = !valid_reg;
    assign result = result_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule
